### hw/rtl/ps2mc_pkg.sv
// shared types and constants for the ps/2 mouse packet cursor
package ps2mc_pkg;

   localparam int COORD_BITS_DEFAULT = 12;

   localparam int BYTE_W   = 8;
   localparam int BUTTON_W = 3;
   localparam int COUNT_W  = 32;
   localparam int DELTA_W  = 9;

   // configuration port
   localparam int CSR_DATA_W = 13;
   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_HEIGHT = 1'b1;

   localparam logic [CSR_DATA_W-1:0] RESET_SCREEN_WIDTH  = 13'd320;
   localparam logic [CSR_DATA_W-1:0] RESET_SCREEN_HEIGHT = 13'd200;
   localparam int RESET_POS_X = 160;
   localparam int RESET_POS_Y = 100;

   // header byte layout
   localparam int HDR_SYNC_BIT    = 3;
   localparam int HDR_X_SIGN_BIT  = 4;
   localparam int HDR_Y_SIGN_BIT  = 5;
   localparam int HDR_X_OVF_BIT   = 6;
   localparam int HDR_Y_OVF_BIT   = 7;

   typedef struct packed {
      logic [BYTE_W-1:0] header;
      logic [BYTE_W-1:0] x_byte;
      logic [BYTE_W-1:0] y_byte;
   } packet_type;

endpackage

### hw/rtl/ps2mc_framer.sv
// byte framer: collects header, x and y bytes into one packet
module ps2mc_framer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ps2mc_pkg::BYTE_W-1:0]  req_rx_byte,
   output logic                          pkt_valid,
   input  logic                          pkt_ready,
   output ps2mc_pkg::packet_type         pkt_data
);

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_XDELTA = 2'd1;
   localparam logic [1:0] PH_YDELTA = 2'd2;

   logic [1:0]                     phase_ff, phase_in;
   logic [ps2mc_pkg::BYTE_W-1:0]   header_ff, header_in;
   logic [ps2mc_pkg::BYTE_W-1:0]   x_byte_ff, x_byte_in;
   logic                           pkt_valid_ff, pkt_valid_in;
   ps2mc_pkg::packet_type          pkt_ff, pkt_in;
   logic                           take;

   assign req_ready = !pkt_valid_ff || pkt_ready;
   assign take      = req_valid && req_ready;
   assign pkt_valid = pkt_valid_ff;
   assign pkt_data  = pkt_ff;

   always_comb begin
      phase_in     = phase_ff;
      header_in    = header_ff;
      x_byte_in    = x_byte_ff;
      pkt_in       = pkt_ff;
      pkt_valid_in = pkt_valid_ff && !pkt_ready;
      if (take) begin
         unique case (phase_ff)
            PH_XDELTA: begin
               x_byte_in = req_rx_byte;
               phase_in  = PH_YDELTA;
            end
            PH_YDELTA: begin
               phase_in = PH_HEADER;
               // overflowed packets are dropped here
               if (!header_ff[ps2mc_pkg::HDR_X_OVF_BIT] &&
                   !header_ff[ps2mc_pkg::HDR_Y_OVF_BIT]) begin
                  pkt_valid_in  = 1'b1;
                  pkt_in.header = header_ff;
                  pkt_in.x_byte = x_byte_ff;
                  pkt_in.y_byte = req_rx_byte;
               end
            end
            default: begin
               // header slot, also the unused code; resync on missing bit 3
               if (req_rx_byte[ps2mc_pkg::HDR_SYNC_BIT]) begin
                  header_in = req_rx_byte;
                  phase_in  = PH_XDELTA;
               end else begin
                  phase_in = PH_HEADER;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         pkt_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pkt_valid_ff <= pkt_valid_in;
      end
      header_ff <= header_in;
      x_byte_ff <= x_byte_in;
      pkt_ff    <= pkt_in;
   end

endmodule

### hw/rtl/ps2mc_cursor.sv
// cursor update: applies packet deltas, clamps, counts and holds the result register
module ps2mc_cursor #(
   parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [ps2mc_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [ps2mc_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                               pkt_valid,
   output logic                               pkt_ready,
   input  ps2mc_pkg::packet_type              pkt_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [COORD_BITS-1:0]              rsp_cursor_x,
   output logic [COORD_BITS-1:0]              rsp_cursor_y,
   output logic [ps2mc_pkg::BUTTON_W-1:0]     rsp_button_bits,
   output logic [ps2mc_pkg::COUNT_W-1:0]      rsp_packet_count
);

   localparam int DW      = ps2mc_pkg::DELTA_W;
   localparam int BOUND_W = COORD_BITS + 1;
   localparam int CMP_W   = (ps2mc_pkg::CSR_DATA_W > BOUND_W) ?
                            ps2mc_pkg::CSR_DATA_W : BOUND_W;
   localparam int SUM_W   = COORD_BITS + 2;
   localparam logic [CMP_W-1:0] LIM = CMP_W'(1) << COORD_BITS;

   logic [ps2mc_pkg::CSR_DATA_W-1:0] width_ff, width_in;
   logic [ps2mc_pkg::CSR_DATA_W-1:0] height_ff, height_in;
   logic [COORD_BITS-1:0]            pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0]            pos_y_ff, pos_y_in;
   logic [ps2mc_pkg::BUTTON_W-1:0]   buttons_ff, buttons_in;
   logic [ps2mc_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]            rsp_x_ff, rsp_y_ff;
   logic [ps2mc_pkg::BUTTON_W-1:0]   rsp_buttons_ff;
   logic [ps2mc_pkg::COUNT_W-1:0]    rsp_count_ff;

   logic [BOUND_W-1:0]       bound_x, bound_y;
   logic [CMP_W-1:0]         wide_x, wide_y;
   logic signed [DW-1:0]     dx, dy;
   logic signed [SUM_W-1:0]  sum_x, sum_y, lim_x, lim_y;
   logic [COORD_BITS-1:0]    new_x, new_y;
   logic                     advance;
   logic                     wr_width, wr_height;
   logic [BOUND_W-1:0]       wb_x, wb_y;
   logic [CMP_W-1:0]         wn;

   // effective bounds: zero acts as one, oversize saturates at 2^COORD_BITS
   always_comb begin
      wide_x = CMP_W'(width_ff);
      if (wide_x == '0) wide_x = CMP_W'(1);
      if (wide_x > LIM) wide_x = LIM;
      wide_y = CMP_W'(height_ff);
      if (wide_y == '0) wide_y = CMP_W'(1);
      if (wide_y > LIM) wide_y = LIM;
      bound_x = wide_x[BOUND_W-1:0];
      bound_y = wide_y[BOUND_W-1:0];
   end

   assign pkt_ready = !rsp_valid_ff || rsp_ready;
   assign advance   = pkt_valid && pkt_ready;
   assign wr_width  = csr_write_enable && (csr_index == ps2mc_pkg::CSR_SCREEN_WIDTH);
   assign wr_height = csr_write_enable && (csr_index == ps2mc_pkg::CSR_SCREEN_HEIGHT);

   // 9-bit signed deltas
   assign dx = {pkt_data.header[ps2mc_pkg::HDR_X_SIGN_BIT], pkt_data.x_byte};
   assign dy = {pkt_data.header[ps2mc_pkg::HDR_Y_SIGN_BIT], pkt_data.y_byte};

   assign sum_x = $signed({2'b00, pos_x_ff}) + $signed({{(SUM_W-DW){dx[DW-1]}}, dx});
   assign sum_y = $signed({2'b00, pos_y_ff}) - $signed({{(SUM_W-DW){dy[DW-1]}}, dy});
   assign lim_x = $signed({1'b0, bound_x});
   assign lim_y = $signed({1'b0, bound_y});

   always_comb begin
      priority if (sum_x < 0)      new_x = '0;
      else if (sum_x >= lim_x)     new_x = COORD_BITS'(bound_x - BOUND_W'(1));
      else                         new_x = sum_x[COORD_BITS-1:0];
      priority if (sum_y < 0)      new_y = '0;
      else if (sum_y >= lim_y)     new_y = COORD_BITS'(bound_y - BOUND_W'(1));
      else                         new_y = sum_y[COORD_BITS-1:0];
   end

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      buttons_in   = buttons_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (advance) begin
         pos_x_in     = new_x;
         pos_y_in     = new_y;
         buttons_in   = pkt_data.header[ps2mc_pkg::BUTTON_W-1:0];
         count_in     = count_ff + ps2mc_pkg::COUNT_W'(1);
         rsp_valid_in = 1'b1;
      end
      // a bound write recenters the matching coordinate
      if (wr_width) begin
         width_in = csr_write_data;
      end
      if (wr_height) begin
         height_in = csr_write_data;
      end
   end

   // recenter value from the freshly written bound
   always_comb begin
      wn = CMP_W'(csr_write_data);
      if (wn == '0) wn = CMP_W'(1);
      if (wn > LIM) wn = LIM;
      wb_x = wn[BOUND_W-1:0];
      wb_y = wn[BOUND_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= ps2mc_pkg::RESET_SCREEN_WIDTH;
         height_ff    <= ps2mc_pkg::RESET_SCREEN_HEIGHT;
         pos_x_ff     <= COORD_BITS'(ps2mc_pkg::RESET_POS_X);
         pos_y_ff     <= COORD_BITS'(ps2mc_pkg::RESET_POS_Y);
         buttons_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         pos_x_ff     <= wr_width  ? wb_x[BOUND_W-1:1] : pos_x_in;
         pos_y_ff     <= wr_height ? wb_y[BOUND_W-1:1] : pos_y_in;
         buttons_ff   <= buttons_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_x_ff       <= new_x;
         rsp_y_ff       <= new_y;
         rsp_buttons_ff <= buttons_in;
         rsp_count_ff   <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cursor_x     = rsp_x_ff;
   assign rsp_cursor_y     = rsp_y_ff;
   assign rsp_button_bits  = rsp_buttons_ff;
   assign rsp_packet_count = rsp_count_ff;

   // cursor always stays inside its bounds
   a_x_in_bounds: assert property (@(posedge clock) disable iff (reset)
      {1'b0, pos_x_ff} < bound_x)
      else $error("cursor x outside bound");

   a_y_in_bounds: assert property (@(posedge clock) disable iff (reset)
      {1'b0, pos_y_ff} < bound_y)
      else $error("cursor y outside bound");

   // every transfer into the result register carries the next count
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff && (rsp_count_ff == $past(count_ff) + ps2mc_pkg::COUNT_W'(1)))
      else $error("packet count did not step by one");

   // a width write recenters x
   a_recenter_x: assert property (@(posedge clock) disable iff (reset)
      wr_width |=> pos_x_ff == $past(wb_x[BOUND_W-1:1]))
      else $error("width write did not recenter x");

endmodule

### hw/rtl/ps2_mouse_packet_cursor.sv
// top level of the ps/2 mouse packet decoder with clamped cursor
// after the transfer of a packet's third byte, it passes the packet register, then the result register
// throughput: one byte per cycle while req_ready is high; each packet result takes three bytes
// a stalled result holds the packet register, which then holds the byte input
// reset (synchronous): framer back to the header slot, bounds 320 by 200,
// cursor at 160,100, buttons and packet count zero, no result pending
module ps2_mouse_packet_cursor #(
   parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // byte input channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ps2mc_pkg::BYTE_W-1:0]       req_rx_byte,
   // packet result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [COORD_BITS-1:0]              rsp_cursor_x,
   output logic [COORD_BITS-1:0]              rsp_cursor_y,
   output logic [ps2mc_pkg::BUTTON_W-1:0]     rsp_button_bits,
   output logic [ps2mc_pkg::COUNT_W-1:0]      rsp_packet_count,
   // bound registers, write only
   input  logic                               csr_write_enable,
   input  logic [ps2mc_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [ps2mc_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   // framed packet between the framer and the cursor stage
   logic                  pkt_valid;
   logic                  pkt_ready;
   ps2mc_pkg::packet_type pkt_data;

   // stage one: header sync, byte collection, overflow drop
   ps2mc_framer u_framer (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .pkt_valid   (pkt_valid),
      .pkt_ready   (pkt_ready),
      .pkt_data    (pkt_data)
   );

   // stage two: sign extend deltas, move and clamp the cursor,
   // latch buttons, count the packet, register the result
   ps2mc_cursor #(
      .COORD_BITS (COORD_BITS)
   ) u_cursor (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pkt_valid        (pkt_valid),
      .pkt_ready        (pkt_ready),
      .pkt_data         (pkt_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cursor_x     (rsp_cursor_x),
      .rsp_cursor_y     (rsp_cursor_y),
      .rsp_button_bits  (rsp_button_bits),
      .rsp_packet_count (rsp_packet_count)
   );

endmodule
